@@ rtl/bank_page_allocator_assert.svh @@
// Assertion macros for the bank page allocator, empty when synthesized.
`ifndef BANK_PAGE_ALLOCATOR_ASSERT_SVH
`define BANK_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bank_page_allocator: assertion failed");
// Next-cycle implication.
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bank_page_allocator: assertion failed");
`else
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bpa_pkg.sv @@
// Shared widths, codes and controller/datapath structs of the bank page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int PAGE_W     = 16;
	localparam int ADDR_W     = 48;
	localparam int COUNT_W    = 10;
	localparam int STATUS_W   = 2;
	localparam int BANK_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	localparam int MAX_BANKS_DEF      = 64;
	localparam int PAGES_PER_BANK_DEF = 512;
	localparam int HUGE_RUN_PAGES_DEF = 512;
	localparam int PAGE_BYTES_DEF     = 4096;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BANK_PAGES = 2'd2;

	typedef struct packed {
		logic load_item;
		logic clr_start;
		logic clr_step;
		logic scan_start;
		logic scan_run;
		logic pass3;
		logic open_prep;
		logic open_bank;
		logic take_mul;
		logic take_write;
		logic set_oom;
		logic set_clear;
		logic out_push;
	} bpa_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic is_huge;
		logic clr_done;
		logic scan_hit;
		logic scan_done;
		logic can_open;
		logic out_space;
	} bpa_stat_t;

endpackage

@@ rtl/bpa_req_if.sv @@
// Request channel: operation and page count with valid/ready.
`timescale 1ns / 1ps

interface bpa_req_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [bpa_pkg::COUNT_W-1:0]  page_count;

	modport source (output valid, output operation, output page_count, input ready);
	modport sink (input valid, input operation, input page_count, output ready);
endinterface

@@ rtl/bpa_rsp_if.sv @@
// Response channel: allocation result with valid/ready.
`timescale 1ns / 1ps

interface bpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bpa_pkg::STATUS_W-1:0]  status;
	logic [bpa_pkg::BANK_W-1:0]    bank_index;
	logic [bpa_pkg::ADDR_W-1:0]    guest_address;
	logic                          was_dirty;
	logic                          opened_bank;

	modport source (output valid, output status, output bank_index, output guest_address,
		output was_dirty, output opened_bank, input ready);
	modport sink (input valid, input status, input bank_index, input guest_address,
		input was_dirty, input opened_bank, output ready);
endinterface

@@ rtl/bpa_ctrl.sv @@
// Sequencing state machine of the bank page allocator.
`timescale 1ns / 1ps

module bpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpa_pkg::bpa_stat_t stat,
	output bpa_pkg::bpa_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_CLEAR    = 4'd2;
	localparam logic [3:0] S_SCAN     = 4'd3;
	localparam logic [3:0] S_DECIDE   = 4'd4;
	localparam logic [3:0] S_OPEN     = 4'd5;
	localparam logic [3:0] S_TMUL     = 4'd6;
	localparam logic [3:0] S_TWRITE   = 4'd7;
	localparam logic [3:0] S_PUSH     = 4'd8;

	logic [3:0] state_q, state_d;
	logic       pass3_q, pass3_d;

	always_comb begin
		state_d   = state_q;
		pass3_d   = pass3_q;
		cmd       = '0;
		cmd.pass3 = pass3_q;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_clear) begin
					cmd.clr_start = 1'b1;
					state_d       = S_CLEAR;
				end else begin
					cmd.scan_start = 1'b1;
					pass3_d        = 1'b0;
					state_d        = S_SCAN;
				end
			end
			S_CLEAR: begin
				if (stat.clr_done) begin
					cmd.set_clear = 1'b1;
					state_d       = S_PUSH;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_hit) begin
					state_d = S_TMUL;
				end else if (stat.scan_done) begin
					if (pass3_q) begin
						cmd.set_oom = 1'b1;
						state_d     = S_PUSH;
					end else begin
						state_d = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				cmd.open_prep = 1'b1;
				if (stat.can_open) begin
					state_d = S_OPEN;
				end else if (stat.is_huge) begin
					// rescan, rounding each bank's use up to huge alignment
					cmd.scan_start = 1'b1;
					pass3_d        = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.set_oom = 1'b1;
					state_d     = S_PUSH;
				end
			end
			S_OPEN: begin
				cmd.open_bank = 1'b1;
				state_d       = S_PUSH;
			end
			S_TMUL: begin
				cmd.take_mul = 1'b1;
				state_d      = S_TWRITE;
			end
			S_TWRITE: begin
				cmd.take_write = 1'b1;
				state_d        = S_PUSH;
			end
			S_PUSH: begin
				if (stat.out_space) begin
					cmd.out_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass3_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass3_q <= pass3_d;
		end
	end

endmodule

@@ rtl/bpa_dp.sv @@
// Datapath: bank tables, scan pipeline, counters, config and result registers.
`timescale 1ns / 1ps

module bpa_dp #(
	parameter int MAX_BANKS      = bpa_pkg::MAX_BANKS_DEF,
	parameter int PAGES_PER_BANK = bpa_pkg::PAGES_PER_BANK_DEF,
	parameter int HUGE_RUN_PAGES = bpa_pkg::HUGE_RUN_PAGES_DEF,
	parameter int PAGE_BYTES     = bpa_pkg::PAGE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_operation,
	input  logic [bpa_pkg::COUNT_W-1:0]       in_page_count,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [bpa_pkg::STATUS_W-1:0]      out_status,
	output logic [bpa_pkg::BANK_W-1:0]        out_bank_index,
	output logic [bpa_pkg::ADDR_W-1:0]        out_guest_address,
	output logic                              out_was_dirty,
	output logic                              out_opened_bank,
	input  bpa_pkg::bpa_cmd_t                 cmd,
	output bpa_pkg::bpa_stat_t                stat
);

	localparam int PAGE_W  = bpa_pkg::PAGE_W;
	localparam int ADDR_W  = bpa_pkg::ADDR_W;
	localparam int COUNT_W = bpa_pkg::COUNT_W;
	localparam int AW      = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
	localparam int CW      = $clog2(MAX_BANKS + 1);
	localparam int RND_W   = PAGE_W + 1;
	localparam int SUM3_W  = PAGE_W + 2;
	localparam int PB_W    = $clog2(PAGE_BYTES + 1);
	localparam int PROD_W  = PAGE_W + PB_W;
	// floor(x / HUGE_RUN_PAGES) for 16-bit x as (x * RC_M) >> RC_SH
	localparam int H_L     = $clog2(HUGE_RUN_PAGES);
	localparam int RC_SH   = PAGE_W + H_L;
	localparam int RC_W    = PAGE_W + 1;
	localparam int RP_W    = PAGE_W + RC_W;
	localparam longint unsigned RC_M =
		((64'd1 << RC_SH) + HUGE_RUN_PAGES - 1) / HUGE_RUN_PAGES;
	localparam logic [RC_W-1:0]    RC_MUL  = RC_W'(RC_M);
	localparam logic [PAGE_W-1:0]  HUGE_P  = PAGE_W'(HUGE_RUN_PAGES);
	localparam logic [COUNT_W-1:0] HUGE_N  = COUNT_W'(HUGE_RUN_PAGES);
	localparam logic [PAGE_W-1:0]  PPB     = PAGE_W'(PAGES_PER_BANK);
	localparam logic [PROD_W-1:0]  PB_MUL  = PROD_W'(PAGE_BYTES);
	localparam logic [CW-1:0]      BANKS_C = CW'(MAX_BANKS);

	// configuration and global state
	logic [PAGE_W-1:0] max_pages_q, first_bank_pages_q, pages_opened_q;
	logic [ADDR_W-1:0] next_base_q;
	logic [CW-1:0]     open_banks_q, clr_idx_q, scan_idx_q;

	// current item
	logic               op_q;
	logic [COUNT_W-1:0] n_q;
	logic [PAGE_W-1:0]  n16;
	logic               is_huge;

	// bank tables
	logic [PAGE_W-1:0] used_mem  [MAX_BANKS];
	logic [PAGE_W-1:0] dirty_mem [MAX_BANKS];
	logic [PAGE_W-1:0] pages_mem [MAX_BANKS];
	logic [ADDR_W-1:0] base_mem  [MAX_BANKS];

	logic [AW-1:0]     wr_addr, rd_addr;
	logic              used_we, dirty_we, bank_we;
	logic [PAGE_W-1:0] used_wd, dirty_wd;

	// scan pipeline
	logic              issue;
	logic              valid_s1, valid_s2, valid_s3;
	logic [AW-1:0]     idx_s1, idx_s2, idx_s3;
	logic [PAGE_W-1:0] used_s1, used_s2, used_s3;
	logic [PAGE_W-1:0] dirty_s1, dirty_s2, dirty_s3;
	logic [PAGE_W-1:0] pages_s1, pages_s2, pages_s3;
	logic [ADDR_W-1:0] base_s1, base_s2, base_s3;
	logic [PAGE_W-1:0] q_s2;
	logic [RND_W-1:0]  rnd_s3;
	logic [RP_W-1:0]   rc_prod;
	logic [PAGE_W-1:0] q_d, qh;
	logic [RND_W-1:0]  rnd_d;
	logic [RND_W-1:0]  sum1;
	logic [SUM3_W-1:0] sum3;
	logic              fit1, fit3, fit;

	// take and open
	logic [AW-1:0]     tk_idx_q;
	logic [PAGE_W-1:0] tk_u_q, tk_dirty_q, tk_new;
	logic [ADDR_W-1:0] tk_base_q;
	logic [PROD_W-1:0] prod_q;
	logic [PAGE_W-1:0] new_size, mul_a, open_fill;
	logic [PAGE_W:0]   pages_sum;
	logic              oversize;

	// result staging and output register
	logic [bpa_pkg::STATUS_W-1:0] res_status_q;
	logic [bpa_pkg::BANK_W-1:0]   res_bank_q;
	logic [ADDR_W-1:0]            res_addr_q;
	logic                         res_dirty_q, res_opened_q;
	logic                         out_valid_q;

	assign n16      = PAGE_W'(n_q);
	assign is_huge  = (n_q == HUGE_N);
	assign new_size = (open_banks_q == '0 && first_bank_pages_q != '0) ?
		first_bank_pages_q : PPB;
	assign oversize  = (n16 > new_size);
	assign open_fill = oversize ? '0 : n16;
	assign pages_sum = {1'b0, pages_opened_q} + {1'b0, new_size};
	assign tk_new    = tk_u_q + n16;
	assign mul_a     = cmd.open_prep ? new_size : tk_u_q;

	// table write port: clear sweep, bank open, or take
	always_comb begin
		wr_addr  = '0;
		used_we  = 1'b0;
		dirty_we = 1'b0;
		bank_we  = 1'b0;
		used_wd  = '0;
		dirty_wd = '0;
		if (cmd.clr_step) begin
			wr_addr  = clr_idx_q[AW-1:0];
			used_we  = 1'b1;
			// bank 0 keeps its high-water mark across a usage reset
			dirty_we = (clr_idx_q != '0);
		end else if (cmd.open_bank) begin
			wr_addr  = open_banks_q[AW-1:0];
			used_we  = 1'b1;
			dirty_we = 1'b1;
			bank_we  = 1'b1;
			used_wd  = open_fill;
			dirty_wd = open_fill;
		end else if (cmd.take_write) begin
			wr_addr  = tk_idx_q;
			used_we  = 1'b1;
			dirty_we = 1'b1;
			used_wd  = tk_new;
			dirty_wd = (tk_new > tk_dirty_q) ? tk_new : tk_dirty_q;
		end
	end

	assign rd_addr = scan_idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[wr_addr] <= used_wd;
		end
		if (dirty_we) begin
			dirty_mem[wr_addr] <= dirty_wd;
		end
		if (bank_we) begin
			pages_mem[wr_addr] <= new_size;
			base_mem[wr_addr]  <= next_base_q;
		end
		if (cmd.scan_run) begin
			used_s1  <= used_mem[rd_addr];
			dirty_s1 <= dirty_mem[rd_addr];
			pages_s1 <= pages_mem[rd_addr];
			base_s1  <= base_mem[rd_addr];
		end
	end

	// scan pipeline: read, quotient, rounded use, fit check
	assign issue   = cmd.scan_run && (scan_idx_q < open_banks_q);
	assign rc_prod = RP_W'(used_s1) * RP_W'(RC_MUL);
	assign q_d     = PAGE_W'(rc_prod >> RC_SH);
	assign qh      = q_s2 * HUGE_P;
	assign rnd_d   = (qh == used_s2) ? RND_W'(used_s2) : RND_W'(qh) + RND_W'(HUGE_P);

	always_ff @(posedge clk) begin
		if (cmd.scan_run) begin
			idx_s1   <= rd_addr;
			idx_s2   <= idx_s1;
			idx_s3   <= idx_s2;
			q_s2     <= q_d;
			used_s2  <= used_s1;
			dirty_s2 <= dirty_s1;
			pages_s2 <= pages_s1;
			base_s2  <= base_s1;
			rnd_s3   <= rnd_d;
			used_s3  <= used_s2;
			dirty_s3 <= dirty_s2;
			pages_s3 <= pages_s2;
			base_s3  <= base_s2;
		end
	end

	assign sum1 = RND_W'(used_s3) + RND_W'(n_q);
	assign sum3 = SUM3_W'(rnd_s3) + SUM3_W'(n_q);
	assign fit1 = (!is_huge || rnd_s3 == RND_W'(used_s3)) && (sum1 <= RND_W'(pages_s3));
	assign fit3 = (sum3 <= SUM3_W'(pages_s3));
	assign fit  = cmd.pass3 ? fit3 : fit1;

	always_comb begin
		stat.is_clear  = (op_q == bpa_pkg::OP_CLEAR);
		stat.is_huge   = is_huge;
		stat.clr_done  = (clr_idx_q >= open_banks_q);
		stat.scan_hit  = valid_s3 && fit;
		stat.scan_done = (scan_idx_q >= open_banks_q) && !valid_s1 && !valid_s2 && !valid_s3;
		stat.can_open  = (pages_opened_q < max_pages_q) && (open_banks_q < BANKS_C);
		stat.out_space = !out_valid_q || out_ready;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q <= in_operation;
			n_q  <= in_page_count;
		end
		if (cmd.scan_run && stat.scan_hit) begin
			tk_idx_q   <= idx_s3;
			tk_u_q     <= cmd.pass3 ? rnd_s3[PAGE_W-1:0] : used_s3;
			tk_dirty_q <= dirty_s3;
			tk_base_q  <= base_s3;
		end
		if (cmd.open_prep || cmd.take_mul) begin
			prod_q <= PROD_W'(mul_a) * PB_MUL;
		end
		if (cmd.set_clear || cmd.set_oom) begin
			res_status_q <= cmd.set_oom ? bpa_pkg::ST_OOM : bpa_pkg::ST_OK;
			res_bank_q   <= '0;
			res_addr_q   <= '0;
			res_dirty_q  <= 1'b0;
			res_opened_q <= 1'b0;
		end else if (cmd.open_bank) begin
			res_status_q <= oversize ? bpa_pkg::ST_TOO_BIG : bpa_pkg::ST_OK;
			res_bank_q   <= bpa_pkg::BANK_W'(open_banks_q);
			res_addr_q   <= oversize ? '0 : next_base_q;
			res_dirty_q  <= 1'b0;
			res_opened_q <= 1'b1;
		end else if (cmd.take_write) begin
			res_status_q <= bpa_pkg::ST_OK;
			res_bank_q   <= bpa_pkg::BANK_W'(tk_idx_q);
			res_addr_q   <= tk_base_q + ADDR_W'(prod_q);
			res_dirty_q  <= (tk_u_q < tk_dirty_q);
			res_opened_q <= 1'b0;
		end
		if (cmd.out_push) begin
			out_status        <= res_status_q;
			out_bank_index    <= res_bank_q;
			out_guest_address <= res_addr_q;
			out_was_dirty     <= res_dirty_q;
			out_opened_bank   <= res_opened_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pages_q        <= '0;
			first_bank_pages_q <= '0;
			pages_opened_q     <= '0;
			next_base_q        <= '0;
			open_banks_q       <= '0;
			clr_idx_q          <= '0;
			scan_idx_q         <= '0;
			valid_s1           <= 1'b0;
			valid_s2           <= 1'b0;
			valid_s3           <= 1'b0;
			out_valid_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bpa_pkg::CFG_MAX_PAGES: begin
						max_pages_q <= cfg_data[PAGE_W-1:0];
					end
					bpa_pkg::CFG_ARENA_BASE: begin
						if (open_banks_q == '0) begin
							next_base_q <= cfg_data[ADDR_W-1:0];
						end
					end
					bpa_pkg::CFG_FIRST_BANK_PAGES: begin
						first_bank_pages_q <= cfg_data[PAGE_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.open_bank) begin
				open_banks_q   <= open_banks_q + 1'b1;
				pages_opened_q <= pages_sum[PAGE_W] ? '1 : pages_sum[PAGE_W-1:0];
				next_base_q    <= next_base_q + ADDR_W'(prod_q);
			end
			if (cmd.clr_start) begin
				clr_idx_q <= '0;
			end else if (cmd.clr_step) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				valid_s1   <= 1'b0;
				valid_s2   <= 1'b0;
				valid_s3   <= 1'b0;
			end else if (cmd.scan_run) begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				valid_s1 <= issue;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
			if (cmd.out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/bank_page_allocator.sv @@
// Bank page allocator top level: controller, datapath and the three channels.
// A request scans the open banks in order and is served by the first with room; the slowest
// path is a missed scan, then a huge rescan hitting the last bank. A bank is opened only
// after a scan of all open banks finds no room; a usage reset sweeps every open bank.
// One item at a time; the scan reads one table entry per cycle.
// Reset clears control, counters and configuration; bank tables hold junk until opened.
`timescale 1ns / 1ps
`include "bank_page_allocator_assert.svh"

module bank_page_allocator #(
	parameter int MAX_BANKS      = bpa_pkg::MAX_BANKS_DEF,
	parameter int PAGES_PER_BANK = bpa_pkg::PAGES_PER_BANK_DEF,
	parameter int HUGE_RUN_PAGES = bpa_pkg::HUGE_RUN_PAGES_DEF,
	parameter int PAGE_BYTES     = bpa_pkg::PAGE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bpa_req_if.sink                        req,
	bpa_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Controller and datapath talk only through these two structs.
	bpa_pkg::bpa_cmd_t  cmd;
	bpa_pkg::bpa_stat_t stat;

	// The controller sequences one item: dispatch on operation, then either sweep
	// the open banks clearing use counts, or scan for the first bank with room,
	// fall back to opening a bank, or, if none can open, rescan huge runs with aligned use.
	// Input ready is high only while idle; the finished result sits in the
	// datapath's output register, so the next beat is taken while it waits.
	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the per-bank tables (use count, high-water mark, size,
	// base address) in single-write-port arrays, the scan pipeline that rounds
	// each bank's use to huge alignment with a reciprocal multiply, the page
	// budget and next-base counters, the configuration registers and the
	// result/output registers.
	bpa_dp #(
		.MAX_BANKS      (MAX_BANKS),
		.PAGES_PER_BANK (PAGES_PER_BANK),
		.HUGE_RUN_PAGES (HUGE_RUN_PAGES),
		.PAGE_BYTES     (PAGE_BYTES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_operation      (req.operation),
		.in_page_count     (req.page_count),
		.out_ready         (rsp.ready),
		.out_valid         (rsp.valid),
		.out_status        (rsp.status),
		.out_bank_index    (rsp.bank_index),
		.out_guest_address (rsp.guest_address),
		.out_was_dirty     (rsp.was_dirty),
		.out_opened_bank   (rsp.opened_bank),
		.cmd               (cmd),
		.stat              (stat)
	);

	// An accepted beat drops ready until its result has been pushed.
	`BPA_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, req.valid && req.ready, !req.ready)
	// Never overwrite a result the sink has not taken.
	`BPA_ASSERT_NOW(a_push_has_room, clk, arst_n, cmd.out_push, !rsp.valid || rsp.ready)
	// A scan cannot both find a bank and report it ran dry.
	`BPA_ASSERT_NOW(a_hit_not_done, clk, arst_n, stat.scan_hit, !stat.scan_done)
	// A bank opens only within budget and table size.
	`BPA_ASSERT_NOW(a_open_allowed, clk, arst_n, cmd.open_bank, stat.can_open)

endmodule
